@@ rtl/ledtw_pkg.sv @@
`timescale 1ns / 1ps

package ledtw_pkg;

  // Item command codes
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_START = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // Bytes sent on the two-wire bus, and the brightness mask and reset value
  localparam logic [7:0] BYTE_DATA_CMD = 8'h40;
  localparam logic [7:0] BYTE_ADDR_CMD = 8'hC0;
  localparam logic [7:0] BYTE_CTRL_CMD = 8'h80;
  localparam logic [7:0] BYTE_KEYS_CMD = 8'h42;
  localparam logic [7:0] BYTE_CTRL_ON  = 8'h08;
  localparam logic [2:0] BRIGHT_MASK   = 3'h7;
  localparam logic [2:0] BRIGHT_RESET  = 3'd5;

  // One input item
  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0] digit_index;
    logic [7:0] segment_bits;
    logic       dio_in;
  } item_t;

  // One result item
  typedef struct packed {
    logic       clk_level;
    logic       dio_level;
    logic       dio_release;
    logic       busy_res;
    logic [7:0] key_code;
    logic       key_valid;
  } result_t;

endpackage

@@ rtl/ledtw_if.sv @@
`timescale 1ns / 1ps

// Input item channel
interface ledtw_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [2:0] digit_index;
  logic [7:0] segment_bits;
  logic       dio_in;

  modport source (output valid, cmd, digit_index, segment_bits, dio_in, input ready);
  modport sink   (input valid, cmd, digit_index, segment_bits, dio_in, output ready);
endinterface

// Result item channel
interface ledtw_result_if;
  logic       valid;
  logic       ready;
  logic       clk_level;
  logic       dio_level;
  logic       dio_release;
  logic       busy_res;
  logic [7:0] key_code;
  logic       key_valid;

  modport source (output valid, clk_level, dio_level, dio_release, busy_res, key_code,
                  key_valid, input ready);
  modport sink   (input valid, clk_level, dio_level, dio_release, busy_res, key_code,
                  key_valid, output ready);
endinterface

@@ rtl/ledtw_store.sv @@
`timescale 1ns / 1ps

// Digit segment store: one write port, one combinational read port.
// Entries beyond DEPTH are ignored on write and read as zero.
module ledtw_store #(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       we,
  input  logic [2:0] waddr,
  input  logic [7:0] wdata,
  input  logic [2:0] raddr,
  output logic [7:0] rdata
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [2:0] DEPTH_W = 3'(DEPTH);

  logic [7:0] mem [DEPTH];

  // write, cleared on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) mem[i] <= 8'd0;
    end else if (we && (waddr < DEPTH_W)) begin
      mem[waddr[IW-1:0]] <= wdata;
    end
  end

  // read
  assign rdata = (raddr < DEPTH_W) ? mem[raddr[IW-1:0]] : 8'd0;

endmodule

@@ rtl/ledtw_seq.sv @@
`timescale 1ns / 1ps

// Frame sequencer: one item per step, each tick is one half-bit phase.
module ledtw_seq #(
  parameter int DIGITS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  ledtw_pkg::item_t  item,
  input  logic [2:0]        brightness,
  output ledtw_pkg::result_t res
);

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_S1_START = 4'd1,
    PH_S1_BYTE  = 4'd2,
    PH_S1_STOP  = 4'd3,
    PH_S2_START = 4'd4,
    PH_S2_ADDR  = 4'd5,
    PH_S2_DATA  = 4'd6,
    PH_S2_STOP  = 4'd7,
    PH_S3_START = 4'd8,
    PH_S3_CTRL  = 4'd9,
    PH_S3_STOP  = 4'd10,
    PH_S4_START = 4'd11,
    PH_S4_CMD   = 4'd12,
    PH_S4_READ  = 4'd13,
    PH_S4_STOP  = 4'd14
  } phase_t;

  localparam logic [2:0] DIGITS_W = 3'(DIGITS);

  phase_t     phase, phase_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [3:0] bit_cnt, bit_cnt_next;
  logic [2:0] byte_cnt, byte_cnt_next;
  logic       half, half_next;
  logic [7:0] key_reg, key_reg_next;
  logic       pin_clk, pin_clk_next;
  logic       pin_dio, pin_dio_next;
  logic       pin_rel, pin_rel_next;
  logic       done;
  logic [2:0] byte_inc;
  logic [2:0] rd_addr;
  logic [7:0] rd_data;
  logic [7:0] ctrl_byte;
  logic       store_we;

  assign byte_inc  = byte_cnt + 3'd1;
  assign rd_addr   = (phase == PH_S2_DATA) ? byte_inc : 3'd0;
  assign ctrl_byte = (ledtw_pkg::BYTE_CTRL_CMD | ledtw_pkg::BYTE_CTRL_ON)
                     + {5'd0, brightness & ledtw_pkg::BRIGHT_MASK};
  assign store_we  = step && (ledtw_pkg::cmd_t'(item.cmd) == ledtw_pkg::CMD_WRITE);

  ledtw_store #(.DEPTH(DIGITS)) u_store (
    .clk  (clk),
    .rst  (rst),
    .we   (store_we),
    .waddr(item.digit_index),
    .wdata(item.segment_bits),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // next-state logic for one item
  always_comb begin
    phase_next      = phase;
    shift_byte_next = shift_byte;
    bit_cnt_next    = bit_cnt;
    byte_cnt_next   = byte_cnt;
    half_next       = half;
    key_reg_next    = key_reg;
    pin_clk_next    = pin_clk;
    pin_dio_next    = pin_dio;
    pin_rel_next    = pin_rel;
    done            = 1'b0;

    if (step) begin
      unique case (ledtw_pkg::cmd_t'(item.cmd))
        ledtw_pkg::CMD_START: begin
          if (phase == PH_IDLE) begin
            phase_next    = PH_S1_START;
            half_next     = 1'b0;
            bit_cnt_next  = 4'd0;
            byte_cnt_next = 3'd0;
          end
        end
        ledtw_pkg::CMD_TICK: begin
          unique case (phase)
            PH_IDLE: begin
            end
            // start condition, then load the byte of the next phase
            PH_S1_START, PH_S2_START, PH_S3_START, PH_S4_START: begin
              if (!half) begin
                {pin_clk_next, pin_dio_next, pin_rel_next} = 3'b110;
                half_next = 1'b1;
              end else begin
                {pin_clk_next, pin_dio_next, pin_rel_next} = 3'b100;
                half_next     = 1'b0;
                bit_cnt_next  = 4'd0;
                byte_cnt_next = 3'd0;
                unique case (phase)
                  PH_S1_START: begin
                    phase_next      = PH_S1_BYTE;
                    shift_byte_next = ledtw_pkg::BYTE_DATA_CMD;
                  end
                  PH_S2_START: begin
                    phase_next      = PH_S2_ADDR;
                    shift_byte_next = ledtw_pkg::BYTE_ADDR_CMD;
                  end
                  PH_S3_START: begin
                    phase_next      = PH_S3_CTRL;
                    shift_byte_next = ctrl_byte;
                  end
                  default: begin
                    phase_next      = PH_S4_CMD;
                    shift_byte_next = ledtw_pkg::BYTE_KEYS_CMD;
                  end
                endcase
              end
            end
            // byte out LSB first, then one ack clock
            PH_S1_BYTE, PH_S2_ADDR, PH_S2_DATA, PH_S3_CTRL, PH_S4_CMD: begin
              if (!bit_cnt[3]) begin
                pin_dio_next = shift_byte[0];
                pin_rel_next = 1'b0;
                if (!half) begin
                  pin_clk_next = 1'b0;
                  half_next    = 1'b1;
                end else begin
                  pin_clk_next    = 1'b1;
                  half_next       = 1'b0;
                  shift_byte_next = {1'b0, shift_byte[7:1]};
                  bit_cnt_next    = bit_cnt + 4'd1;
                end
              end else if (!half) begin
                {pin_clk_next, pin_dio_next, pin_rel_next} = 3'b001;
                half_next = 1'b1;
              end else begin
                {pin_clk_next, pin_dio_next, pin_rel_next} = 3'b101;
                half_next    = 1'b0;
                bit_cnt_next = 4'd0;
                unique case (phase)
                  PH_S2_DATA: begin
                    byte_cnt_next = byte_inc;
                    if (byte_inc < DIGITS_W) shift_byte_next = rd_data;
                    else phase_next = PH_S2_STOP;
                  end
                  PH_S2_ADDR: begin
                    phase_next      = PH_S2_DATA;
                    byte_cnt_next   = 3'd0;
                    shift_byte_next = rd_data;
                  end
                  PH_S4_CMD: begin
                    phase_next      = PH_S4_READ;
                    shift_byte_next = 8'd0;
                  end
                  PH_S1_BYTE: phase_next = PH_S1_STOP;
                  default:    phase_next = PH_S3_STOP;
                endcase
              end
            end
            // key bits in MSB first, then one ack clock
            PH_S4_READ: begin
              pin_dio_next = 1'b0;
              pin_rel_next = 1'b1;
              if (!half) begin
                pin_clk_next = 1'b0;
                half_next    = 1'b1;
                if (!bit_cnt[3]) shift_byte_next = {shift_byte[6:0], item.dio_in};
              end else begin
                pin_clk_next = 1'b1;
                half_next    = 1'b0;
                if (!bit_cnt[3]) begin
                  bit_cnt_next = bit_cnt + 4'd1;
                end else begin
                  bit_cnt_next = 4'd0;
                  phase_next   = PH_S4_STOP;
                end
              end
            end
            // stop condition over three ticks
            PH_S1_STOP, PH_S2_STOP, PH_S3_STOP, PH_S4_STOP: begin
              half_next = 1'b0;
              if (bit_cnt == 4'd0) begin
                {pin_clk_next, pin_dio_next, pin_rel_next} = 3'b000;
                bit_cnt_next = 4'd1;
              end else if (bit_cnt == 4'd1) begin
                {pin_clk_next, pin_dio_next, pin_rel_next} = 3'b100;
                bit_cnt_next = 4'd2;
              end else begin
                {pin_clk_next, pin_dio_next, pin_rel_next} = 3'b110;
                bit_cnt_next = 4'd0;
                unique case (phase)
                  PH_S4_STOP: begin
                    key_reg_next = shift_byte;
                    phase_next   = PH_IDLE;
                    done         = 1'b1;
                  end
                  PH_S1_STOP: phase_next = PH_S2_START;
                  PH_S2_STOP: phase_next = PH_S3_START;
                  default:    phase_next = PH_S4_START;
                endcase
              end
            end
            default: begin
              phase_next   = PH_IDLE;
              half_next    = 1'b0;
              bit_cnt_next = 4'd0;
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      shift_byte <= 8'd0;
      bit_cnt    <= 4'd0;
      byte_cnt   <= 3'd0;
      half       <= 1'b0;
      key_reg    <= 8'd0;
      pin_clk    <= 1'b1;
      pin_dio    <= 1'b1;
      pin_rel    <= 1'b0;
    end else begin
      phase      <= phase_next;
      shift_byte <= shift_byte_next;
      bit_cnt    <= bit_cnt_next;
      byte_cnt   <= byte_cnt_next;
      half       <= half_next;
      key_reg    <= key_reg_next;
      pin_clk    <= pin_clk_next;
      pin_dio    <= pin_dio_next;
      pin_rel    <= pin_rel_next;
    end
  end

  // result of the item being stepped
  always_comb begin
    res.clk_level   = pin_clk_next;
    res.dio_level   = pin_dio_next;
    res.dio_release = pin_rel_next;
    res.busy_res    = (phase_next != PH_IDLE);
    res.key_code    = key_reg_next;
    res.key_valid   = done;
  end

endmodule

@@ rtl/led_display_two_wire_refresh_master.sv @@
`timescale 1ns / 1ps
// Throughput: one item per cycle while the result side takes results; every
// item, tick or write, is one step. An accepted item goes through the input
// register, then a sequencer step into the result register, held until taken.
// Reset (rst, synchronous): frame idle, digit store and key byte zero,
// brightness 5, bus idle (clock high, data high, driven); no result pending.
module led_display_two_wire_refresh_master #(
  parameter int DIGITS = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  ledtw_item_if.sink            req,
  ledtw_result_if.source        rsp,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_data
);

  logic               iv;
  ledtw_pkg::item_t   item_q;
  logic               ov;
  ledtw_pkg::result_t res_q;
  ledtw_pkg::result_t seq_res;
  logic [2:0]         brightness;
  logic               adv;

  // item moves on when the result register is free or being emptied
  assign adv       = iv && (!ov || rsp.ready);
  assign req.ready = !iv || adv;

  // brightness register
  always_ff @(posedge clk) begin
    if (rst) brightness <= ledtw_pkg::BRIGHT_RESET;
    else if (cfg_we) brightness <= cfg_data & ledtw_pkg::BRIGHT_MASK;
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (req.ready) begin
      iv <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item_q.cmd          <= req.cmd;
      item_q.digit_index  <= req.digit_index;
      item_q.segment_bits <= req.segment_bits;
      item_q.dio_in       <= req.dio_in;
    end
  end

  ledtw_seq #(.DIGITS(DIGITS)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .step      (adv),
    .item      (item_q),
    .brightness(brightness),
    .res       (seq_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (adv) begin
      ov <= 1'b1;
    end else if (rsp.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) res_q <= seq_res;
  end

  assign rsp.valid       = ov;
  assign rsp.clk_level   = res_q.clk_level;
  assign rsp.dio_level   = res_q.dio_level;
  assign rsp.dio_release = res_q.dio_release;
  assign rsp.busy_res    = res_q.busy_res;
  assign rsp.key_code    = res_q.key_code;
  assign rsp.key_valid   = res_q.key_valid;

  // a completed frame leaves the bus idle and the sequencer free
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    ov && res_q.key_valid |-> !res_q.busy_res && res_q.clk_level && res_q.dio_level
                              && !res_q.dio_release)
    else $error("frame completion without idle bus");

  // released data pin is reported low
  a_release_low: assert property (@(posedge clk) disable iff (rst)
    ov && res_q.dio_release |-> !res_q.dio_level)
    else $error("data level driven while released");

  // a held item is not dropped while the result side stalls
  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    iv && !adv |=> iv)
    else $error("input item lost under stall");

  // a stepped item always lands in the result register
  a_step_result: assert property (@(posedge clk) disable iff (rst)
    adv |=> ov)
    else $error("stepped item produced no result");

endmodule

@@ dv/ledtw_frame_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels, keeps its own copy of the refresh sequencer and
// compares every result item with the pin levels it predicts.
module ledtw_frame_checker #(
  parameter int DIGITS = 4
) (
  input  logic       clk,
  input  logic       rst,
  ledtw_item_if      req,
  ledtw_result_if    rsp,
  input  logic       cfg_we,
  input  logic [2:0] cfg_data,
  output int         fail_count,
  output int         outstanding,
  output logic       frame_busy,
  output int         items_seen,
  output int         frames_done
);

  localparam int IW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  // Sequencer position within one refresh frame
  typedef enum logic [4:0] {
    SEQ_IDLE,
    DATA_START, DATA_BYTE, DATA_STOP,
    ADDR_START, ADDR_BYTE, DIGIT_BYTES, ADDR_STOP,
    CTRL_START, CTRL_BYTE, CTRL_STOP,
    KEYS_START, KEYS_BYTE, KEYS_READ, KEYS_STOP
  } frame_phase_t;

  // Predicted block state
  logic [7:0]   segs [DIGITS];
  logic [2:0]   bright;
  frame_phase_t seq;
  logic [7:0]   sr;
  logic [3:0]   nbit;
  logic [2:0]   ndig;
  logic         half;
  logic [7:0]   keys;
  logic         lvl_clk, lvl_dio, lvl_rel;

  ledtw_pkg::result_t pin_levels_q [$];
  ledtw_pkg::result_t got, want;
  ledtw_pkg::item_t   it;
  int           fails = 0;
  int           n_items = 0;
  int           n_frames = 0;

  function automatic logic [7:0] byte_to_send(frame_phase_t p);
    case (p)
      DATA_BYTE:   return ledtw_pkg::BYTE_DATA_CMD;
      ADDR_BYTE:   return ledtw_pkg::BYTE_ADDR_CMD;
      DIGIT_BYTES: return (int'(ndig) < DIGITS) ? segs[ndig[IW-1:0]] : 8'h00;
      CTRL_BYTE:   return (ledtw_pkg::BYTE_CTRL_CMD | ledtw_pkg::BYTE_CTRL_ON)
                          + {5'b0, bright & ledtw_pkg::BRIGHT_MASK};
      KEYS_BYTE:   return ledtw_pkg::BYTE_KEYS_CMD;
      default:     return 8'h00;
    endcase
  endfunction

  function automatic void set_pins(logic c, logic d, logic r);
    lvl_clk = c;
    lvl_dio = d;
    lvl_rel = r;
  endfunction

  // One half-bit phase of the frame
  task automatic refresh_tick(input logic dio, output logic done);
    done = 1'b0;
    case (seq)
      DATA_START, ADDR_START, CTRL_START, KEYS_START: begin
        if (!half) begin
          set_pins(1'b1, 1'b1, 1'b0);
          half = 1'b1;
        end else begin
          set_pins(1'b1, 1'b0, 1'b0);
          half = 1'b0;
          seq  = frame_phase_t'(seq + 5'd1);
          nbit = '0;
          ndig = '0;
          sr   = byte_to_send(seq);
        end
      end
      DATA_BYTE, ADDR_BYTE, DIGIT_BYTES, CTRL_BYTE, KEYS_BYTE: begin
        if (nbit < 4'd8) begin
          // data bits, LSB first
          if (!half) begin
            set_pins(1'b0, sr[0], 1'b0);
            half = 1'b1;
          end else begin
            set_pins(1'b1, sr[0], 1'b0);
            half = 1'b0;
            sr   = sr >> 1;
            nbit = nbit + 4'd1;
          end
        end else if (!half) begin
          set_pins(1'b0, 1'b0, 1'b1);
          half = 1'b1;
        end else begin
          // second half of the ack clock: move on
          set_pins(1'b1, 1'b0, 1'b1);
          half = 1'b0;
          nbit = '0;
          case (seq)
            DIGIT_BYTES: begin
              ndig = ndig + 3'd1;
              if (int'(ndig) < DIGITS) sr = byte_to_send(DIGIT_BYTES);
              else seq = ADDR_STOP;
            end
            ADDR_BYTE: begin
              seq  = DIGIT_BYTES;
              ndig = '0;
              sr   = byte_to_send(DIGIT_BYTES);
            end
            KEYS_BYTE: begin
              seq = KEYS_READ;
              sr  = 8'h00;
            end
            default: seq = frame_phase_t'(seq + 5'd1);
          endcase
        end
      end
      KEYS_READ: begin
        if (nbit < 4'd8) begin
          // key bits, MSB first, sampled on the low half
          if (!half) begin
            set_pins(1'b0, 1'b0, 1'b1);
            sr   = {sr[6:0], dio};
            half = 1'b1;
          end else begin
            set_pins(1'b1, 1'b0, 1'b1);
            half = 1'b0;
            nbit = nbit + 4'd1;
          end
        end else if (!half) begin
          set_pins(1'b0, 1'b0, 1'b1);
          half = 1'b1;
        end else begin
          set_pins(1'b1, 1'b0, 1'b1);
          half = 1'b0;
          nbit = '0;
          seq  = KEYS_STOP;
        end
      end
      DATA_STOP, ADDR_STOP, CTRL_STOP, KEYS_STOP: begin
        half = 1'b0;
        if (nbit == 4'd0) begin
          set_pins(1'b0, 1'b0, 1'b0);
          nbit = 4'd1;
        end else if (nbit == 4'd1) begin
          set_pins(1'b1, 1'b0, 1'b0);
          nbit = 4'd2;
        end else begin
          set_pins(1'b1, 1'b1, 1'b0);
          nbit = '0;
          if (seq == KEYS_STOP) begin
            keys = sr;
            seq  = SEQ_IDLE;
            done = 1'b1;
          end else begin
            seq = frame_phase_t'(seq + 5'd1);
          end
        end
      end
      default: begin
        seq  = SEQ_IDLE;
        half = 1'b0;
        nbit = '0;
      end
    endcase
  endtask

  // Expected result for one accepted item
  task automatic predict_item(input ledtw_pkg::item_t x, output ledtw_pkg::result_t r);
    logic done;
    done = 1'b0;
    case (x.cmd)
      ledtw_pkg::CMD_WRITE:
        if (int'(x.digit_index) < DIGITS) segs[x.digit_index[IW-1:0]] = x.segment_bits;
      ledtw_pkg::CMD_START: begin
        if (seq == SEQ_IDLE) begin
          seq  = DATA_START;
          half = 1'b0;
          nbit = '0;
          ndig = '0;
        end
      end
      ledtw_pkg::CMD_TICK: if (seq != SEQ_IDLE) refresh_tick(x.dio_in, done);
      default:   ;
    endcase
    r.clk_level   = lvl_clk;
    r.dio_level   = lvl_dio;
    r.dio_release = lvl_rel;
    r.busy_res    = (seq != SEQ_IDLE);
    r.key_code    = keys;
    r.key_valid   = done;
  endtask

  function automatic int field_diff(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  // Sample both channels at the clock edge
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIGITS; i++) segs[i] = 8'h00;
      bright = ledtw_pkg::BRIGHT_RESET;
      seq    = SEQ_IDLE;
      sr     = 8'h00;
      nbit   = '0;
      ndig   = '0;
      half   = 1'b0;
      keys   = 8'h00;
      set_pins(1'b1, 1'b1, 1'b0);
      pin_levels_q.delete();
    end else begin
      if (cfg_we) bright = cfg_data & ledtw_pkg::BRIGHT_MASK;

      if (rsp.valid && rsp.ready) begin
        got.clk_level   = rsp.clk_level;
        got.dio_level   = rsp.dio_level;
        got.dio_release = rsp.dio_release;
        got.busy_res    = rsp.busy_res;
        got.key_code    = rsp.key_code;
        got.key_valid   = rsp.key_valid;
        if (pin_levels_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result item, expected none actual %0h", $time, got);
        end else begin
          want = pin_levels_q.pop_front();
          fails += field_diff("clk_level", want.clk_level, got.clk_level);
          fails += field_diff("dio_level", want.dio_level, got.dio_level);
          fails += field_diff("dio_release", want.dio_release, got.dio_release);
          fails += field_diff("busy_res", want.busy_res, got.busy_res);
          fails += field_diff("key_code", want.key_code, got.key_code);
          fails += field_diff("key_valid", want.key_valid, got.key_valid);
        end
      end

      if (req.valid && req.ready) begin
        it.cmd          = req.cmd;
        it.digit_index  = req.digit_index;
        it.segment_bits = req.segment_bits;
        it.dio_in       = req.dio_in;
        predict_item(it, want);
        pin_levels_q.push_back(want);
        n_items++;
        if (want.key_valid) n_frames++;
      end
    end
    fail_count  <= fails;
    outstanding <= pin_levels_q.size();
    frame_busy  <= (seq != SEQ_IDLE);
    items_seen  <= n_items;
    frames_done <= n_frames;
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int DIGITS      = 4;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 140;
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 300;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [2:0] cfg_data;

  int   gap_max;
  int   stall_max;
  int   dio_mode;
  int   results_taken;
  int   fail_count;
  int   outstanding;
  int   items_seen;
  int   frames_done;
  logic frame_busy;

  ledtw_item_if   req_if ();
  ledtw_result_if rsp_if ();

  led_display_two_wire_refresh_master #(
    .DIGITS (DIGITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_if),
    .rsp      (rsp_if),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  ledtw_frame_checker #(
    .DIGITS (DIGITS)
  ) pin_watch (
    .clk         (clk),
    .rst         (rst),
    .req         (req_if),
    .rsp         (rsp_if),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .frame_busy  (frame_busy),
    .items_seen  (items_seen),
    .frames_done (frames_done)
  );

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop
  initial begin
    #2_000_000;
    $display("led_display_two_wire_refresh_master regression: fail");
    $finish;
  end

  // Offer one item after a random gap, return at its handshake
  task automatic send_item(ledtw_pkg::cmd_t c, logic [2:0] idx, logic [7:0] seg, logic dio);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.cmd          <= c;
    req_if.digit_index  <= idx;
    req_if.segment_bits <= seg;
    req_if.dio_in       <= dio;
    do @(posedge clk); while (!req_if.ready);
  endtask

  // Mostly ticks so frames run through, with writes, starts and no-ops mixed in
  task automatic send_random();
    int              r;
    logic            d;
    ledtw_pkg::cmd_t c;
    r = $urandom_range(0, 99);
    case (dio_mode)
      1:       d = 1'b1;
      2:       d = 1'b0;
      default: d = 1'($urandom);
    endcase
    if (r < 74)      c = ledtw_pkg::CMD_TICK;
    else if (r < 86) c = ledtw_pkg::CMD_WRITE;
    else if (r < 94) c = ledtw_pkg::CMD_START;
    else             c = ledtw_pkg::CMD_NONE;
    send_item(c, 3'($urandom), 8'($urandom), d);
  endtask

  // Tick the current frame to its end, then let the block drain
  task automatic close_frame();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (frame_busy) begin
      send_item(ledtw_pkg::CMD_TICK, 3'($urandom), 8'($urandom), 1'($urandom));
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Result side: random stall per item, one long hold-off
  initial begin
    int stall;
    rsp_if.ready <= 1'b0;
    results_taken = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = (results_taken == HOLD_AT) ? HOLD_CYCLES : $urandom_range(0, stall_max);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
      results_taken++;
    end
  end

  // Stimulus
  initial begin
    logic [2:0] b;
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_data            <= ledtw_pkg::BRIGHT_RESET;
    req_if.valid        <= 1'b0;
    req_if.cmd          <= ledtw_pkg::CMD_NONE;
    req_if.digit_index  <= 3'd0;
    req_if.segment_bits <= 8'h00;
    req_if.dio_in       <= 1'b0;
    gap_max   = 19;
    stall_max = 19;
    dio_mode  = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // idle tick, no-op, store extremes, ignored indexes
    send_item(ledtw_pkg::CMD_TICK,  3'd7, 8'hFF, 1'b1);
    send_item(ledtw_pkg::CMD_NONE,  3'd0, 8'h00, 1'b0);
    send_item(ledtw_pkg::CMD_WRITE, 3'd0, 8'hFF, 1'b1);
    send_item(ledtw_pkg::CMD_WRITE, 3'd3, 8'h00, 1'b0);
    send_item(ledtw_pkg::CMD_WRITE, 3'd1, 8'hA5, 1'b0);
    send_item(ledtw_pkg::CMD_WRITE, 3'd2, 8'h5A, 1'b1);
    send_item(ledtw_pkg::CMD_WRITE, 3'd4, 8'hFF, 1'b0);
    send_item(ledtw_pkg::CMD_WRITE, 3'd7, 8'h81, 1'b1);
    // start, then a second start while busy
    send_item(ledtw_pkg::CMD_START, 3'd5, 8'h00, 1'b0);
    send_item(ledtw_pkg::CMD_START, 3'd2, 8'hFF, 1'b1);
    send_item(ledtw_pkg::CMD_TICK,  3'd0, 8'h00, 1'b1);
    send_item(ledtw_pkg::CMD_TICK,  3'd0, 8'h00, 1'b0);
    send_item(ledtw_pkg::CMD_TICK,  3'd7, 8'hFF, 1'b1);
    send_item(ledtw_pkg::CMD_TICK,  3'd7, 8'hFF, 1'b0);
    // store write and no-op in the middle of a frame
    send_item(ledtw_pkg::CMD_WRITE, 3'd0, 8'h3C, 1'b0);
    send_item(ledtw_pkg::CMD_NONE,  3'd7, 8'hFF, 1'b1);
    send_item(ledtw_pkg::CMD_TICK,  3'd1, 8'h11, 1'b0);
    send_item(ledtw_pkg::CMD_TICK,  3'd1, 8'h11, 1'b1);
    send_item(ledtw_pkg::CMD_TICK,  3'd6, 8'hEE, 1'b0);
    send_item(ledtw_pkg::CMD_TICK,  3'd6, 8'hEE, 1'b1);

    // random phases, each at its own brightness and idling mix
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        case (p)
          1:       b = 3'd0;
          2:       b = 3'd7;
          3:       b = 3'd2;
          4:       b = 3'd6;
          default: b = 3'($urandom);
        endcase
        cfg_we   <= 1'b1;
        cfg_data <= b;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
      end
      gap_max   = (p % 3 == 1) ? 0 : 19;
      stall_max = (p % 3 == 2) ? 0 : 19;
      dio_mode  = p % 3;
      repeat (PHASE_ITEMS) send_random();
      close_frame();
    end

    repeat (10) @(posedge clk);
    $display("Run covered %0d items over %0d brightness settings, %0d full refresh frames.",
             items_seen, PHASES, frames_done);
    $display("Result side held off for %0d cycles once while items kept coming.", HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("led_display_two_wire_refresh_master regression: pass");
    end else begin
      $display("led_display_two_wire_refresh_master regression: fail");
    end
    $finish;
  end

endmodule
